// ===== sv/csab_pkg.sv =====
`default_nettype none
package csab_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam int CFG_W = 13;
  localparam int CHAN_W = 8;
  localparam int IDX_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int BLEND_SHIFT = 8;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR = 8'd0;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST = 13'd1024;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST = 13'd64;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd64;
  localparam logic [CFG_W-1:0] ORIGIN_RST = 13'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_FRAME_WIDTH   = 3'd2,
    REG_FRAME_HEIGHT  = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_ORIGIN_Y      = 3'd5
  } cfg_reg_t;

  // dst + ((alpha * (src - dst)) >>> 8), wrapped to 8 bits
  function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] src,
                                              input logic [CHAN_W-1:0] dst,
                                              input logic [CHAN_W-1:0] alpha);
    logic signed [CHAN_W:0] diff;
    logic signed [2*CHAN_W+1:0] prod;
    logic signed [2*CHAN_W+1:0] shifted;
    diff = $signed({1'b0, src}) - $signed({1'b0, dst});
    prod = $signed({1'b0, alpha}) * diff;
    shifted = prod >>> BLEND_SHIFT;
    return dst + shifted[CHAN_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/csab_tex_if.sv =====
`default_nettype none
interface csab_tex_if;
  logic valid;
  logic ready;
  logic [csab_pkg::CHAN_W-1:0] tex_blue;
  logic [csab_pkg::CHAN_W-1:0] tex_green;
  logic [csab_pkg::CHAN_W-1:0] tex_red;
  logic [csab_pkg::CHAN_W-1:0] tex_alpha;
  logic [csab_pkg::CHAN_W-1:0] dst_blue;
  logic [csab_pkg::CHAN_W-1:0] dst_green;
  logic [csab_pkg::CHAN_W-1:0] dst_red;

  modport source (
    output valid, tex_blue, tex_green, tex_red, tex_alpha, dst_blue, dst_green, dst_red,
    input  ready
  );
  modport sink (
    input  valid, tex_blue, tex_green, tex_red, tex_alpha, dst_blue, dst_green, dst_red,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/csab_pix_if.sv =====
`default_nettype none
interface csab_pix_if;
  logic valid;
  logic ready;
  logic write_enable;
  logic [csab_pkg::IDX_W-1:0] pixel_index;
  logic [csab_pkg::CHAN_W-1:0] out_blue;
  logic [csab_pkg::CHAN_W-1:0] out_green;
  logic [csab_pkg::CHAN_W-1:0] out_red;
  logic frame_done;

  modport source (
    output valid, write_enable, pixel_index, out_blue, out_green, out_red, frame_done,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_index, out_blue, out_green, out_red, frame_done,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/clipped_alpha_sprite_blitter_core.sv =====
// Sprite blitter: blends one sprite frame onto the screen, one texel per clock while pix is not stalled.
// tex channel (valid/ready): one texel of the frame in raster order, with the
//   screen colour currently at its position.
// pix channel (valid/ready): one pixel transaction per texel: write enable,
//   screen pixel index, colour to write, and a flag on the frame's last texel.
// cfg port: write enable, register index, 13-bit data; the user must write it only while idle (not enforced).
// Pipeline: a texel taken on tex passes a position/clip register, then the
//   multiply-and-blend result register, whose contents are offered on pix.
// Throughput: one texel per clock unless pix stalls, set by the two-register
//   pipeline; the pix output register holds a finished result while the
//   next texel enters.
// Stall: when pix.ready is low the output register holds, the position stage
//   fills, and tex.ready drops until the output is taken.
// Reset: pipeline empty, column and row counts zero, registers at their
//   defaults (1024 x 768 screen, 64 x 64 frame, origin 0,0).
`default_nettype none
module clipped_alpha_sprite_blitter_core #(
  parameter int MAX_DIM = csab_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [csab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [csab_pkg::CFG_W-1:0]      cfg_data,
  csab_tex_if.sink                             tex,
  csab_pix_if.source                           pix
);

  localparam int CFG_W = csab_pkg::CFG_W;
  localparam int CHAN_W = csab_pkg::CHAN_W;
  localparam int IDX_W = csab_pkg::IDX_W;
  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int XW = DW + 1;
  localparam int PW = DW + CFG_W;
  localparam logic [DW-1:0] MAX_DIM_D = DW'(MAX_DIM);

  // configuration
  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CFG_W-1:0] origin_x;
  logic [CFG_W-1:0] origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= csab_pkg::SCREEN_WIDTH_RST;
      screen_height <= csab_pkg::SCREEN_HEIGHT_RST;
      frame_width   <= csab_pkg::FRAME_WIDTH_RST;
      frame_height  <= csab_pkg::FRAME_HEIGHT_RST;
      origin_x      <= csab_pkg::ORIGIN_RST;
      origin_y      <= csab_pkg::ORIGIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        csab_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        csab_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        csab_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        csab_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        csab_pkg::REG_ORIGIN_X:      origin_x      <= cfg_data;
        csab_pkg::REG_ORIGIN_Y:      origin_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid;
  logic s1_valid_next;
  logic o_valid;
  logic o_valid_next;
  logic tex_acc;
  logic advance;

  assign advance = s1_valid && (!o_valid || pix.ready);
  assign tex.ready = !s1_valid || advance;
  assign tex_acc = tex.valid && tex.ready;

  always_comb begin
    s1_valid_next = s1_valid;
    if (tex_acc) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end
    o_valid_next = o_valid;
    if (advance) begin
      o_valid_next = 1'b1;
    end else if (pix.ready) begin
      o_valid_next = 1'b0;
    end
  end

  // frame position
  logic [CW-1:0] col_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] col_count_next;
  logic [CW-1:0] row_count_next;
  logic [DW-1:0] fw_eff;
  logic [DW-1:0] fh_eff;
  logic          line_end;
  logic          done;
  logic signed [XW-1:0] pos_x;
  logic signed [XW-1:0] pos_y;
  logic          on_screen;

  always_comb begin
    fw_eff = DW'(frame_width);
    if (frame_width == '0) begin
      fw_eff = DW'(1);
    end else if (fw_eff > MAX_DIM_D) begin
      fw_eff = MAX_DIM_D;
    end
    fh_eff = DW'(frame_height);
    if (frame_height == '0) begin
      fh_eff = DW'(1);
    end else if (fh_eff > MAX_DIM_D) begin
      fh_eff = MAX_DIM_D;
    end
  end

  assign line_end = (DW'(col_count) + DW'(1)) >= fw_eff;
  assign done = line_end && ((DW'(row_count) + DW'(1)) >= fh_eff);

  assign pos_x = $signed({{(XW-CFG_W){origin_x[CFG_W-1]}}, origin_x})
               + $signed({{(XW-CW){1'b0}}, col_count});
  assign pos_y = $signed({{(XW-CFG_W){origin_y[CFG_W-1]}}, origin_y})
               + $signed({{(XW-CW){1'b0}}, row_count});
  assign on_screen = !pos_x[XW-1] && !pos_y[XW-1]
               && (pos_x[XW-2:0] < (XW-1)'(screen_width))
               && (pos_y[XW-2:0] < (XW-1)'(screen_height));

  always_comb begin
    col_count_next = col_count + CW'(1);
    row_count_next = row_count;
    if (done) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if (line_end) begin
      col_count_next = '0;
      row_count_next = row_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (tex_acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // stage 1: texel, clip result and screen position
  logic [CHAN_W-1:0] s1_tex_blue;
  logic [CHAN_W-1:0] s1_tex_green;
  logic [CHAN_W-1:0] s1_tex_red;
  logic [CHAN_W-1:0] s1_tex_alpha;
  logic [CHAN_W-1:0] s1_dst_blue;
  logic [CHAN_W-1:0] s1_dst_green;
  logic [CHAN_W-1:0] s1_dst_red;
  logic              s1_inside;
  logic              s1_done;
  logic [XW-2:0]     s1_x;
  logic [XW-2:0]     s1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tex_acc) begin
      s1_tex_blue  <= tex.tex_blue;
      s1_tex_green <= tex.tex_green;
      s1_tex_red   <= tex.tex_red;
      s1_tex_alpha <= tex.tex_alpha;
      s1_dst_blue  <= tex.dst_blue;
      s1_dst_green <= tex.dst_green;
      s1_dst_red   <= tex.dst_red;
      s1_inside    <= on_screen;
      s1_done      <= done;
      s1_x         <= pos_x[XW-2:0];
      s1_y         <= pos_y[XW-2:0];
    end
  end

  // stage 2: pixel index and blend
  logic [PW-1:0]     index_full;
  logic              we_next;
  logic [IDX_W-1:0]  index_next;
  logic [CHAN_W-1:0] blue_next;
  logic [CHAN_W-1:0] green_next;
  logic [CHAN_W-1:0] red_next;

  assign index_full = PW'(s1_y) * PW'(screen_width) + PW'(s1_x);

  always_comb begin
    we_next    = 1'b0;
    index_next = '0;
    blue_next  = s1_dst_blue;
    green_next = s1_dst_green;
    red_next   = s1_dst_red;
    if (s1_inside) begin
      index_next = index_full[IDX_W-1:0];
      if (s1_tex_alpha == csab_pkg::ALPHA_OPAQUE) begin
        we_next    = 1'b1;
        blue_next  = s1_tex_blue;
        green_next = s1_tex_green;
        red_next   = s1_tex_red;
      end else if (s1_tex_alpha != csab_pkg::ALPHA_CLEAR) begin
        we_next    = 1'b1;
        blue_next  = csab_pkg::blend(s1_tex_blue, s1_dst_blue, s1_tex_alpha);
        green_next = csab_pkg::blend(s1_tex_green, s1_dst_green, s1_tex_alpha);
        red_next   = csab_pkg::blend(s1_tex_red, s1_dst_red, s1_tex_alpha);
      end
    end
  end

  logic              o_write_enable;
  logic [IDX_W-1:0]  o_pixel_index;
  logic [CHAN_W-1:0] o_blue;
  logic [CHAN_W-1:0] o_green;
  logic [CHAN_W-1:0] o_red;
  logic              o_frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_write_enable <= we_next;
      o_pixel_index  <= index_next;
      o_blue         <= blue_next;
      o_green        <= green_next;
      o_red          <= red_next;
      o_frame_done   <= s1_done;
    end
  end

  assign pix.valid        = o_valid;
  assign pix.write_enable = o_write_enable;
  assign pix.pixel_index  = o_pixel_index;
  assign pix.out_blue     = o_blue;
  assign pix.out_green    = o_green;
  assign pix.out_red      = o_red;
  assign pix.frame_done   = o_frame_done;

endmodule
`default_nettype wire
